// ===== sv/qtpag_pkg.sv =====
`timescale 1ns / 1ps

package qtpag_pkg;

    // Fixed field widths of the pixel and result words, the dimension registers and the APB port
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 26;
    localparam int CFG_DIM_W  = 13;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register map: index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } reg_idx_t;

    // Rotation direction
    typedef enum logic {
        TURN_90  = 1'b0,
        TURN_270 = 1'b1
    } turn_t;

    // One pixel as it travels through the block
    typedef struct packed {
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte0;
    } pixel_t;

    localparam int PIXEL_W = $bits(pixel_t);

endpackage

// ===== sv/qtpag_if.sv =====
`timescale 1ns / 1ps

// Incoming pixel channel
interface qtpag_pixel_if
    import qtpag_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte0;
    logic [BYTE_W-1:0] pixel_byte1;
    logic [BYTE_W-1:0] pixel_byte2;

    modport src (output valid, pixel_byte0, pixel_byte1, pixel_byte2, input ready);
    modport snk (input valid, pixel_byte0, pixel_byte1, pixel_byte2, output ready);
endinterface

// Outgoing address channel
interface qtpag_result_if
    import qtpag_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] dest_address;
    logic [BYTE_W-1:0] out_byte0;
    logic [BYTE_W-1:0] out_byte1;
    logic [BYTE_W-1:0] out_byte2;
    logic              frame_last;

    modport src (output valid, dest_address, out_byte0, out_byte1, out_byte2, frame_last,
                 input ready);
    modport snk (input valid, dest_address, out_byte0, out_byte1, out_byte2, frame_last,
                 output ready);
endinterface

// ===== sv/qtpag_front.sv =====
`timescale 1ns / 1ps

module qtpag_front
    import qtpag_pkg::*;
#(
    parameter  int MAX_DIM = 4096,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int CNT_W   = $clog2(MAX_DIM),
    localparam int TERM_W  = DIM_W + 2,
    localparam int ENTRY_W = DIM_W + TERM_W + 1 + PIXEL_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [DIM_W-1:0]    eff_width,
    input  logic [DIM_W-1:0]    eff_height,
    input  turn_t               mode,
    qtpag_pixel_if.snk          pixel,
    input  logic                space,
    output logic                push,
    output logic [ENTRY_W-1:0]  push_data
);

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic              accept;
    logic [DIM_W-1:0]  col_ext, row_ext;
    logic              last_col, last;
    logic [DIM_W-1:0]  factor, row_idx;
    logic [TERM_W-1:0] row_term;
    pixel_t            pix;

    assign pixel.ready = space;
    assign accept      = pixel.valid && space;
    assign push        = accept;

    // Position flags
    assign col_ext  = DIM_W'(col_reg);
    assign row_ext  = DIM_W'(row_reg);
    assign last_col = (col_ext + DIM_W'(1)) == eff_width;
    assign last     = last_col && ((row_ext + DIM_W'(1)) == eff_height);

    // Destination row and column index for the chosen direction
    always_comb
    begin
        case (mode)
            TURN_90:
            begin
                factor  = eff_width - DIM_W'(1) - col_ext;
                row_idx = row_ext;
            end
            TURN_270:
            begin
                factor  = col_ext;
                row_idx = eff_height - DIM_W'(1) - row_ext;
            end
            default:
            begin
                factor  = col_ext;
                row_idx = row_ext;
            end
        endcase
    end

    // row * 3 as shift and add
    assign row_term = TERM_W'({row_idx, 1'b0}) + TERM_W'(row_idx);

    assign pix.byte0 = pixel.pixel_byte0;
    assign pix.byte1 = pixel.pixel_byte1;
    assign pix.byte2 = pixel.pixel_byte2;
    assign push_data = {factor, row_term, last, pix};

    // Raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_reg) < eff_width)
        else $error("column counter outside the frame");

    a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (col_reg == '0) && (row_reg == '0))
        else $error("dimension write did not restart the frame");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters did not wrap after the last pixel");

endmodule

// ===== sv/qtpag_fifo.sv =====
`timescale 1ns / 1ps

module qtpag_fifo
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         space,
    input  logic         pop,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign space     = count_reg < CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> out_valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== sv/qtpag_back.sv =====
`timescale 1ns / 1ps

module qtpag_back
    import qtpag_pkg::*;
#(
    parameter  int MAX_DIM  = 4096,
    localparam int DIM_W    = $clog2(MAX_DIM + 1),
    localparam int TERM_W   = DIM_W + 2,
    localparam int STRIDE_W = $clog2(3 * MAX_DIM + 4),
    localparam int ENTRY_W  = DIM_W + TERM_W + 1 + PIXEL_W,
    localparam int PROD_W   = DIM_W + STRIDE_W + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [STRIDE_W-1:0] stride,
    input  logic                in_valid,
    input  logic [ENTRY_W-1:0]  in_data,
    output logic                pop,
    qtpag_result_if.src         result
);

    logic [DIM_W-1:0]  factor;
    logic [TERM_W-1:0] row_term;
    logic              last;
    pixel_t            pix;
    logic [PROD_W-1:0] addr_full;
    logic              take;

    logic              valid_reg;
    logic [ADDR_W-1:0] addr_reg;
    pixel_t            pix_reg;
    logic              last_reg;

    assign {factor, row_term, last, pix} = in_data;

    // Row offset times stride plus byte column
    assign addr_full = PROD_W'(factor) * PROD_W'(stride) + PROD_W'(row_term);

    // Output register frees when empty or when its word is taken
    assign take = !valid_reg || result.ready;
    assign pop  = in_valid && take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg <= ADDR_W'(addr_full);
            pix_reg  <= pix;
            last_reg <= last;
        end
    end

    assign result.valid        = valid_reg;
    assign result.dest_address = addr_reg;
    assign result.out_byte0    = pix_reg.byte0;
    assign result.out_byte1    = pix_reg.byte1;
    assign result.out_byte2    = pix_reg.byte2;
    assign result.frame_last   = last_reg;

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("popped word not loaded into output");

    a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result.ready) |-> !pop)
        else $error("pop while output stalled");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result.ready && !in_valid) |=> !valid_reg)
        else $error("output stayed valid after its word left");

endmodule

// ===== sv/quarter_turn_pixel_address_gen.sv =====
`timescale 1ns / 1ps
// An accepted pixel is registered in the queue and then in the back stage output register.
// Throughput: one pixel per cycle unless stalled; back stage does one multiply-add per cycle.
// A two-word queue between the counter front end and the multiply back end absorbs stalls.
// Reset (rst_n low, asynchronous): counters to zero, width and height to 1,
// mode to rotate90, queue and output register empty.

module quarter_turn_pixel_address_gen
    import qtpag_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    qtpag_pixel_if.snk            pixel,
    qtpag_result_if.src           result
);

    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int TERM_W   = DIM_W + 2;
    localparam int STRIDE_W = $clog2(3 * MAX_DIM + 4);
    localparam int ENTRY_W  = DIM_W + TERM_W + 1 + PIXEL_W;

    logic [CFG_DIM_W-1:0] width_reg, width_next;
    logic [CFG_DIM_W-1:0] height_reg, height_next;
    turn_t                mode_reg, mode_next;
    logic                 cfg_wr;
    logic                 clear;
    reg_idx_t             reg_idx;

    logic [DIM_W-1:0]     eff_width, eff_height;
    logic [STRIDE_W-1:0]  stride_raw, stride;

    logic                 push, space, q_valid, pop;
    logic [ENTRY_W-1:0]   push_data, q_data;

    // Clamp a dimension register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (32'(v) > 32'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        clear       = 1'b0;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_WIDTH:
                begin
                    width_next = pwdata[CFG_DIM_W-1:0];
                    clear      = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = pwdata[CFG_DIM_W-1:0];
                    clear       = 1'b1;
                end
                REG_MODE:
                begin
                    mode_next = turn_t'(pwdata[0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_DIM_W'(1);
            height_reg <= CFG_DIM_W'(1);
            mode_reg   <= TURN_90;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_MODE:   prdata = APB_DATA_W'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    // Effective dimensions and padded destination stride
    assign eff_width  = clamp_dim(width_reg);
    assign eff_height = clamp_dim(height_reg);
    assign stride_raw = STRIDE_W'({eff_height, 1'b0}) + STRIDE_W'(eff_height) + STRIDE_W'(3);
    assign stride     = {stride_raw[STRIDE_W-1:2], 2'b00};

    qtpag_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .mode       (mode_reg),
        .pixel      (pixel),
        .space      (space),
        .push       (push),
        .push_data  (push_data)
    );

    qtpag_fifo #(.W(ENTRY_W)) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .space      (space),
        .pop        (pop),
        .out_valid  (q_valid),
        .out_data   (q_data)
    );

    qtpag_back #(.MAX_DIM(MAX_DIM)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stride     (stride),
        .in_valid   (q_valid),
        .in_data    (q_data),
        .pop        (pop),
        .result     (result)
    );

endmodule
